// ----- src/rre_pkg.sv -----
// Shared types, constants and register codes of the RTT estimator block.
package rre_pkg;

  // Fixed-point layout of the estimator.
  localparam int SrttFracBits   = 3;
  localparam int RttvarFracBits = 2;
  localparam int SampleBits     = 16;

  // Field widths.
  localparam int ActionW   = 2;
  localparam int SrttW     = 20;
  localparam int VarW      = 20;
  localparam int RtoW      = 24;
  localparam int BackoffW  = 7;
  localparam int DevShiftW = 3;
  localparam int InitRtoW  = 16;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  // Signed working width for the estimator differences.
  localparam int AccW = ((SrttW > SampleBits) ? SrttW : SampleBits) + 3;

  // Width of the scaled variance plus smoothed RTT sum in the timeout path.
  localparam int MaxDevShift = (1 << DevShiftW) - 1;
  localparam int RtoSumW     = VarW + MaxDevShift +
                               ((SrttFracBits > RttvarFracBits) ?
                                (SrttFracBits - RttvarFracBits) : 0) + 1;

  // Backoff limits.
  localparam logic [BackoffW-1:0] BackoffOne  = BackoffW'(1);
  localparam logic [BackoffW-1:0] BackoffCap  = BackoffW'(64);
  localparam logic [BackoffW-1:0] BackoffFold = BackoffW'(8);

  // Reset values of the configuration registers.
  localparam logic                 JacobsonReset = 1'b1;
  localparam logic                 ExpBackReset  = 1'b1;
  localparam logic [DevShiftW-1:0] DevShiftReset = DevShiftW'(2);
  localparam logic [InitRtoW-1:0]  InitRtoReset  = InitRtoW'(30);

  // Input word operations.
  typedef enum logic [ActionW-1:0] {
    ActSample  = 2'd0,
    ActTimeout = 2'd1,
    ActClear   = 2'd2,
    ActNone    = 2'd3
  } rre_action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegJacobsonMode = 2'd0,
    RegExpBackoff   = 2'd1,
    RegDevShift     = 2'd2,
    RegInitRto      = 2'd3
  } rre_reg_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic                 jacobson_mode;
    logic                 exp_backoff_enable;
    logic [DevShiftW-1:0] deviation_shift;
    logic [InitRtoW-1:0]  initial_rto_ticks;
    logic                 rto_load;
  } rre_cfg_t;

  // Estimator state.
  typedef struct packed {
    logic [RtoW-1:0]     rto;
    logic [SrttW-1:0]    srtt;
    logic [VarW-1:0]     rttvar;
    logic [BackoffW-1:0] backoff;
  } rre_state_t;

endpackage

// ----- src/rre_req_if.sv -----
// Input channel: one word per RTT sample, timeout or backoff clear.
interface rre_req_if import rre_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [SampleBits-1:0] sample_ticks;

  modport source (output valid, output action, output sample_ticks, input ready);
  modport sink   (input valid, input action, input sample_ticks, output ready);
endinterface

// ----- src/rre_rsp_if.sv -----
// Output channel: one word per input word with the estimator state after it.
interface rre_rsp_if import rre_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RtoW-1:0]     rto_ticks;
  logic [SrttW-1:0]    smoothed_rtt;
  logic [VarW-1:0]     rtt_variance;
  logic [BackoffW-1:0] backoff_factor;

  modport source (output valid, output rto_ticks, output smoothed_rtt,
                  output rtt_variance, output backoff_factor, input ready);
  modport sink   (input valid, input rto_ticks, input smoothed_rtt,
                  input rtt_variance, input backoff_factor, output ready);
endinterface

// ----- src/rre_cfg_regs.sv -----
// Configuration register bank of the RTT estimator.
module rre_cfg_regs import rre_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output rre_cfg_t            cfg_o
);

  logic                 jacobson_q, jacobson_d;
  logic                 exp_back_q, exp_back_d;
  logic [DevShiftW-1:0] dev_shift_q, dev_shift_d;
  logic [InitRtoW-1:0]  init_rto_q, init_rto_d;
  logic                 rto_load;

  // Register write decoder.
  always_comb begin
    jacobson_d  = jacobson_q;
    exp_back_d  = exp_back_q;
    dev_shift_d = dev_shift_q;
    init_rto_d  = init_rto_q;
    rto_load    = 1'b0;
    if (cfg_we_i) begin
      unique case (rre_reg_e'(cfg_index_i))
        RegJacobsonMode: jacobson_d  = cfg_wdata_i[0];
        RegExpBackoff:   exp_back_d  = cfg_wdata_i[0];
        RegDevShift:     dev_shift_d = cfg_wdata_i[DevShiftW-1:0];
        RegInitRto: begin
          init_rto_d = cfg_wdata_i[InitRtoW-1:0];
          rto_load   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jacobson_q  <= JacobsonReset;
      exp_back_q  <= ExpBackReset;
      dev_shift_q <= DevShiftReset;
      init_rto_q  <= InitRtoReset;
    end else begin
      jacobson_q  <= jacobson_d;
      exp_back_q  <= exp_back_d;
      dev_shift_q <= dev_shift_d;
      init_rto_q  <= init_rto_d;
    end
  end

  // The timeout register takes a newly written initial value at once.
  assign cfg_o.jacobson_mode      = jacobson_q;
  assign cfg_o.exp_backoff_enable = exp_back_q;
  assign cfg_o.deviation_shift    = dev_shift_q;
  assign cfg_o.initial_rto_ticks  = init_rto_d;
  assign cfg_o.rto_load           = rto_load;

endmodule

// ----- src/rre_update.sv -----
// Next-state logic of the estimator for one input word.
module rre_update import rre_pkg::*; (
  input  rre_cfg_t                cfg_i,
  input  rre_state_t              state_i,
  input  logic [ActionW-1:0]      action_i,
  input  logic [SampleBits-1:0]   sample_i,
  output rre_state_t              state_o
);

  localparam logic signed [AccW-1:0] SrttMaxS = AccW'((64'd1 << SrttW) - 64'd1);
  localparam logic signed [AccW-1:0] VarMaxS  = AccW'((64'd1 << VarW) - 64'd1);
  localparam logic signed [AccW-1:0] OneS     = AccW'(1);
  localparam logic [RtoSumW-1:0]     RtoMaxW  = RtoSumW'((64'd1 << RtoW) - 64'd1);
  localparam int                     DevOff   = SrttFracBits - RttvarFracBits;

  // Clamp a signed working value into [1, max] of the smoothed RTT.
  function automatic logic [SrttW-1:0] sat_srtt(input logic signed [AccW-1:0] v);
    logic [SrttW-1:0] r;
    if (v < OneS) r = SrttW'(1);
    else if (v > SrttMaxS) r = SrttMaxS[SrttW-1:0];
    else r = v[SrttW-1:0];
    return r;
  endfunction

  // Clamp a signed working value into [1, max] of the variance.
  function automatic logic [VarW-1:0] sat_var(input logic signed [AccW-1:0] v);
    logic [VarW-1:0] r;
    if (v < OneS) r = VarW'(1);
    else if (v > VarMaxS) r = VarMaxS[VarW-1:0];
    else r = v[VarW-1:0];
    return r;
  endfunction

  logic [SampleBits-1:0]   t;
  logic signed [AccW-1:0]  t_s, srtt_s, var_s, srtt_int, var_int;
  logic signed [AccW-1:0]  diff, abs_d, err, srtt_sum, var_sum;
  logic [AccW-1:0]         seed_srtt, seed_var;
  logic [SrttW-1:0]        samp_srtt;
  logic [VarW-1:0]         samp_var;
  logic [RtoSumW-1:0]      scaled, rto_sum;
  logic [RtoW-1:0]         samp_rto;
  int                      sh;
  logic [BackoffW-1:0]     dbl_backoff;
  logic [VarW:0]           fold_sum;
  logic [VarW-1:0]         fold_var;

  // Sample path: Jacobson/Karels update or seeding of the estimator.
  always_comb begin
    t         = (sample_i == '0) ? SampleBits'(1) : sample_i;
    t_s       = signed'(AccW'(t));
    srtt_s    = signed'(AccW'(state_i.srtt));
    var_s     = signed'(AccW'(state_i.rttvar));
    srtt_int  = signed'(AccW'(state_i.srtt >> SrttFracBits));
    var_int   = signed'(AccW'(state_i.rttvar >> RttvarFracBits));
    diff      = t_s - srtt_int;
    srtt_sum  = srtt_s + diff;
    abs_d     = (diff < 0) ? -diff : diff;
    err       = abs_d - var_int;
    var_sum   = var_s + err;
    seed_srtt = AccW'(t) << SrttFracBits;
    seed_var  = AccW'(t) << (RttvarFracBits - 1);
    if (state_i.srtt != '0) begin
      samp_srtt = sat_srtt(srtt_sum);
      samp_var  = sat_var(var_sum);
    end else begin
      samp_srtt = (seed_srtt > AccW'(SrttMaxS)) ? SrttMaxS[SrttW-1:0]
                                                : seed_srtt[SrttW-1:0];
      samp_var  = (seed_var > AccW'(VarMaxS)) ? VarMaxS[VarW-1:0]
                                              : seed_var[VarW-1:0];
    end
  end

  // Timeout from the updated estimator.
  always_comb begin
    sh = int'(cfg_i.deviation_shift) + DevOff;
    if (sh >= 0) scaled = RtoSumW'(samp_var) << sh;
    else scaled = RtoSumW'(samp_var) >> (-sh);
    rto_sum = (scaled + RtoSumW'(samp_srtt)) >> SrttFracBits;
    if (cfg_i.jacobson_mode) begin
      samp_rto = (rto_sum > RtoMaxW) ? RtoMaxW[RtoW-1:0] : rto_sum[RtoW-1:0];
    end else begin
      samp_rto = RtoW'(samp_srtt >> (SrttFracBits - 1));
    end
  end

  // Timeout word: double the backoff and fold the mean into the variance.
  always_comb begin
    dbl_backoff = (state_i.backoff < BackoffCap) ? (state_i.backoff << 1)
                                                 : state_i.backoff;
    fold_sum    = (VarW + 1)'(state_i.rttvar) +
                  (VarW + 1)'(state_i.srtt >> SrttFracBits);
    fold_var    = fold_sum[VarW] ? {VarW{1'b1}} : fold_sum[VarW-1:0];
  end

  // Select the next state by operation.
  always_comb begin
    state_o = state_i;
    case (rre_action_e'(action_i))
      ActSample: begin
        state_o.srtt   = samp_srtt;
        state_o.rttvar = samp_var;
        state_o.rto    = samp_rto;
      end
      ActTimeout: begin
        if (cfg_i.exp_backoff_enable) begin
          state_o.backoff = dbl_backoff;
          if (dbl_backoff > BackoffFold) begin
            state_o.rttvar = fold_var;
            state_o.srtt   = '0;
          end
        end else begin
          state_o.backoff = BackoffOne;
        end
      end
      ActClear: state_o.backoff = BackoffOne;
      default:  ;
    endcase
  end

endmodule

// ----- src/rtt_estimator_rto_backoff_core.sv -----
// Top level of the RTT estimator with retransmit-timeout backoff.
//
// Words enter on req_i: an RTT sample, a retransmit timeout, or a backoff
// clear. For every accepted word exactly one word leaves on rsp_o, carrying
// the timeout, smoothed RTT, variance and backoff after that word.
// A word is registered on entry; once the output register is free, the
// estimator update runs in one pass of logic and its result lands in the
// output register and the state registers together. The result word is
// valid after the entry and output registers. While rsp_o keeps up, one word
// per cycle is taken, as state feedback closes in the single update stage.
// When the receiver stalls, the output register holds its word and the entry
// register holds one more; req_i.ready then drops until rsp_o drains.
// Reset clears the pipeline, sets the configuration to its defaults, the
// estimator to zero, the backoff to one and the timeout to the initial value.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_wdata_i;
// the user must write it only while the block is idle, which the block does
// not enforce; writing the initial timeout also loads the current timeout.
module rtt_estimator_rto_backoff_core import rre_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  rre_req_if.sink             req_i,
  rre_rsp_if.source           rsp_o
);

  rre_cfg_t              cfg;
  rre_state_t            state_q, state_d, next_state;
  logic                  in_valid_q;
  logic [ActionW-1:0]    in_action_q;
  logic [SampleBits-1:0] in_sample_q;
  logic                  out_valid_q;
  rre_state_t            out_q;
  logic                  advance;
  logic                  accept;

  rre_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rre_update u_update (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .action_i (in_action_q),
    .sample_i (in_sample_q),
    .state_o  (next_state)
  );

  // Handshake: the entry word moves on when the output register frees up.
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  // Entry register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_action_q <= req_i.action;
      in_sample_q <= req_i.sample_ticks;
    end
  end

  // Estimator state: updated per word, timeout reloaded on configuration.
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = next_state;
    end
    if (cfg.rto_load) begin
      state_d.rto = RtoW'(cfg.initial_rto_ticks);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.srtt    <= '0;
      state_q.rttvar  <= '0;
      state_q.backoff <= BackoffOne;
      state_q.rto     <= RtoW'(InitRtoReset);
    end else begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= next_state;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.rto_ticks      = out_q.rto;
  assign rsp_o.smoothed_rtt   = out_q.srtt;
  assign rsp_o.rtt_variance   = out_q.rttvar;
  assign rsp_o.backoff_factor = out_q.backoff;

endmodule

// ----- sim/rtt_estimator_rto_backoff_core_tb.sv -----
// Self-checking testbench of the RTT estimator with retransmit-timeout backoff.
module rtt_estimator_rto_backoff_core_tb import rre_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SrttMax    = (longint'(1) << SrttW) - 1;
  localparam longint VarMax     = (longint'(1) << VarW) - 1;
  localparam longint RtoMax     = (longint'(1) << RtoW) - 1;
  localparam int     CycleLimit = 1000000;
  localparam int     PhaseWords = 250;
  localparam int     PhaseCount = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  rre_req_if req_if ();
  rre_rsp_if rsp_if ();

  rtt_estimator_rto_backoff_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow copy of the configuration and the estimator state.
  logic                 est_jacobson;
  logic                 est_exp_backoff;
  logic [DevShiftW-1:0] est_dev_shift;
  logic [InitRtoW-1:0]  est_init_rto;
  rre_state_t           est_state;
  rre_state_t           expected_words[$];

  int  err_count     = 0;
  int  cycle_count   = 0;
  bit  gaps_on       = 1'b1;
  int  rsp_hold_len  = 0;
  int  rsp_hold_left = 0;
  int  rsp_stall_left = 0;

  always #5 clk_i = ~clk_i;

  function automatic longint saturate(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample values: extremes, small round trips and the full range.
  function automatic logic [SampleBits-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 50) return SampleBits'($urandom_range(1, 255));
    return SampleBits'($urandom);
  endfunction

  // Estimator state after one input word under the current configuration.
  function automatic rre_state_t next_estimate(rre_state_t s, rre_action_e act,
                                               logic [SampleBits-1:0] ticks);
    longint t;
    longint d;
    longint srtt_v;
    longint var_v;
    longint scaled;
    int     sh;
    srtt_v = s.srtt;
    var_v  = s.rttvar;
    case (act)
      ActSample: begin
        // A zero sample counts as one tick.
        t = ticks;
        if (t < 1) t = 1;
        if (srtt_v != 0) begin
          d      = t - (srtt_v >> SrttFracBits);
          srtt_v = saturate(srtt_v + d, 1, SrttMax);
          if (d < 0) d = -d;
          d     = d - (var_v >> RttvarFracBits);
          var_v = saturate(var_v + d, 1, VarMax);
        end else begin
          // Seed both estimates from the first sample.
          srtt_v = saturate(t << SrttFracBits, 0, SrttMax);
          var_v  = saturate(t << (RttvarFracBits - 1), 0, VarMax);
        end
        if (est_jacobson) begin
          sh = int'(est_dev_shift) + SrttFracBits - RttvarFracBits;
          if (sh >= 0) scaled = var_v << sh;
          else scaled = var_v >> (-sh);
          s.rto = RtoW'(saturate((scaled + srtt_v) >> SrttFracBits, 0, RtoMax));
        end else begin
          s.rto = RtoW'(saturate(srtt_v >> (SrttFracBits - 1), 0, RtoMax));
        end
        s.srtt   = SrttW'(srtt_v);
        s.rttvar = VarW'(var_v);
      end
      ActTimeout: begin
        if (est_exp_backoff) begin
          if (s.backoff < BackoffCap) s.backoff = s.backoff << 1;
          // Deep backoff folds the mean into the variance and restarts it.
          if (s.backoff > BackoffFold) begin
            s.rttvar = VarW'(saturate(var_v + (srtt_v >> SrttFracBits), 0, VarMax));
            s.srtt   = '0;
          end
        end else begin
          s.backoff = BackoffOne;
        end
      end
      ActClear: s.backoff = BackoffOne;
      default: ;
    endcase
    return s;
  endfunction

  // Predict on every accepted input word and check every accepted result word.
  always @(posedge clk_i) begin
    rre_state_t exp_word;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        est_state = next_estimate(est_state, rre_action_e'(req_if.action),
                                  req_if.sample_ticks);
        expected_words.push_back(est_state);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation pending");
          err_count++;
        end else begin
          exp_word = expected_words.pop_front();
          if (rsp_if.rto_ticks !== exp_word.rto) begin
            $error("rto_ticks expected %0d, got %0d", exp_word.rto, rsp_if.rto_ticks);
            err_count++;
          end
          if (rsp_if.smoothed_rtt !== exp_word.srtt) begin
            $error("smoothed_rtt expected %0d, got %0d", exp_word.srtt,
                   rsp_if.smoothed_rtt);
            err_count++;
          end
          if (rsp_if.rtt_variance !== exp_word.rttvar) begin
            $error("rtt_variance expected %0d, got %0d", exp_word.rttvar,
                   rsp_if.rtt_variance);
            err_count++;
          end
          if (rsp_if.backoff_factor !== exp_word.backoff) begin
            $error("backoff_factor expected %0d, got %0d", exp_word.backoff,
                   rsp_if.backoff_factor);
            err_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (rsp_hold_len != 0) begin
      rsp_hold_left = rsp_hold_len;
      rsp_hold_len  = 0;
    end
    if (rsp_hold_left > 0) begin
      rsp_hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (rsp_stall_left > 0) begin
      rsp_stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_stall_left = pick_gap();
      rsp_if.ready <= (rsp_stall_left == 0);
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one word after a random gap and wait until it is taken.
  task automatic send_word(rre_action_e act, logic [SampleBits-1:0] ticks);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.sample_ticks <= ticks;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stop offering and wait until every expected word has come back.
  // The wait begins only after the last accepted word is surely queued.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write while the block is idle; the shadow copy follows.
  task automatic write_reg(rre_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegJacobsonMode: est_jacobson = data[0];
      RegExpBackoff:   est_exp_backoff = data[0];
      RegDevShift:     est_dev_shift = data[DevShiftW-1:0];
      RegInitRto: begin
        est_init_rto  = data[InitRtoW-1:0];
        est_state.rto = RtoW'(data[InitRtoW-1:0]);
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // State straight after reset, reported by an unused action.
  task automatic test_reset_state();
    send_word(ActNone, SampleBits'($urandom));
    drain_results();
  endtask

  // Seeding from a zero sample, then swings between the sample extremes.
  task automatic test_estimator_update();
    send_word(ActSample, '0);
    send_word(ActSample, '1);
    send_word(ActSample, SampleBits'(1));
    send_word(ActSample, '1);
    send_word(ActSample, SampleBits'(16'h5555));
    drain_results();
  endtask

  // Backoff doubling, fold past eight, cap at 64, clear and reseed.
  task automatic test_backoff();
    repeat (7) send_word(ActTimeout, SampleBits'($urandom));
    send_word(ActClear, SampleBits'($urandom));
    send_word(ActSample, SampleBits'(16'hAAAA));
    drain_results();
  endtask

  // Each register at its extremes, with a word to show its effect.
  task automatic test_config_sweep();
    write_reg(RegJacobsonMode, 16'hFFFE);
    send_word(ActSample, pick_ticks());
    drain_results();
    write_reg(RegJacobsonMode, 16'h0001);
    write_reg(RegExpBackoff, 16'hFFFE);
    send_word(ActTimeout, SampleBits'($urandom));
    drain_results();
    write_reg(RegExpBackoff, 16'h0001);
    write_reg(RegDevShift, 16'hFFF8);
    send_word(ActSample, pick_ticks());
    drain_results();
    write_reg(RegDevShift, 16'h0004);
    send_word(ActSample, pick_ticks());
    drain_results();
    // Shift values above the nominal range are used as written.
    write_reg(RegDevShift, 16'h0007);
    send_word(ActSample, pick_ticks());
    drain_results();
    write_reg(RegDevShift, 16'h0002);
    // A zero initial timeout is loaded as zero.
    write_reg(RegInitRto, 16'h0000);
    send_word(ActNone, SampleBits'($urandom));
    drain_results();
    write_reg(RegInitRto, 16'h0001);
    send_word(ActNone, SampleBits'($urandom));
    drain_results();
    write_reg(RegInitRto, 16'hFFFF);
    send_word(ActNone, SampleBits'($urandom));
    drain_results();
    write_reg(RegInitRto, 16'd30);
  endtask

  // Long receiver hold-off while words keep coming, so the input stalls.
  task automatic test_output_stall();
    gaps_on      = 1'b0;
    rsp_hold_len = 200;
    repeat (16) send_word(ActSample, pick_ticks());
    drain_results();
    gaps_on = 1'b1;
  endtask

  // Random traffic over several random configurations.
  task automatic test_random_traffic();
    int                  sent;
    int                  chunk_left;
    int                  r;
    int                  n;
    logic [CfgDataW-1:0] w;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      w    = CfgDataW'($urandom);
      w[0] = 1'($urandom_range(0, 1));
      write_reg(RegJacobsonMode, w);
      w    = CfgDataW'($urandom);
      w[0] = ($urandom_range(0, 3) != 0);
      write_reg(RegExpBackoff, w);
      w = CfgDataW'($urandom);
      case ($urandom_range(0, 3))
        0:       w[DevShiftW-1:0] = '0;
        1:       w[DevShiftW-1:0] = DevShiftW'(4);
        default: w[DevShiftW-1:0] = DevShiftW'($urandom_range(0, 7));
      endcase
      write_reg(RegDevShift, w);
      case ($urandom_range(0, 7))
        0:       w = 16'd1;
        1:       w = 16'hFFFF;
        2:       w = 16'd0;
        default: w = CfgDataW'($urandom);
      endcase
      write_reg(RegInitRto, w);
      sent       = 0;
      chunk_left = 0;
      while (sent < PhaseWords) begin
        // Stretches with and without idling on both sides.
        if (chunk_left <= 0) begin
          gaps_on    = ($urandom_range(0, 4) != 0);
          chunk_left = 40;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_word(ActSample, pick_ticks());
          n = 1;
        end else if (r < 77) begin
          // Runs of timeouts reach the fold and the cap.
          n = $urandom_range(1, 8);
          repeat (n) send_word(ActTimeout, SampleBits'($urandom));
        end else if (r < 90) begin
          send_word(ActClear, SampleBits'($urandom));
          n = 1;
        end else begin
          send_word(ActNone, SampleBits'($urandom));
          n = 1;
        end
        sent       += n;
        chunk_left -= n;
      end
      drain_results();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    est_jacobson    = JacobsonReset;
    est_exp_backoff = ExpBackReset;
    est_dev_shift   = DevShiftReset;
    est_init_rto    = InitRtoReset;
    est_state.rto     = RtoW'(InitRtoReset);
    est_state.srtt    = '0;
    est_state.rttvar  = '0;
    est_state.backoff = BackoffOne;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= RegJacobsonMode;
    cfg_wdata_i         <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ActNone;
    req_if.sample_ticks <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_estimator_update();
    test_backoff();
    test_config_sweep();
    test_output_stall();
    test_random_traffic();
    test_output_stall();

    drain_results();
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
